FILE: hdl/mtrd_pkg.sv
// Shared types and constants for the Modbus TCP response deframer.
package mtrd_pkg;

    localparam int QUEUE_DEPTH = 4;

    localparam logic [7:0] EXC_BIT          = 8'h80;
    localparam logic [6:0] FC_READ_HOLDING  = 7'd3;
    localparam logic [6:0] FC_READ_INPUT    = 7'd4;
    localparam logic [6:0] FC_WRITE_SINGLE  = 7'd6;

    localparam logic [16:0] POS_TID_HI   = 17'd0;
    localparam logic [16:0] POS_TID_LO   = 17'd1;
    localparam logic [16:0] POS_LEN_HI   = 17'd4;
    localparam logic [16:0] POS_LEN_LO   = 17'd5;
    localparam logic [16:0] POS_UNIT     = 17'd6;
    localparam logic [16:0] POS_FUNC     = 17'd7;
    localparam logic [16:0] POS_COUNT    = 17'd8;
    localparam logic [16:0] POS_DATA     = 17'd9;
    localparam logic [16:0] POS_WS_HI    = 17'd10;
    localparam logic [16:0] POS_WS_LO    = 17'd11;
    localparam logic [16:0] HDR_LEN      = 17'd6;

    localparam logic [8:0] NEED_PLAIN = 9'd8;
    localparam logic [8:0] NEED_EXC   = 9'd9;
    localparam logic [8:0] NEED_WS    = 9'd12;

    typedef logic [1:0] t_status;
    localparam t_status ST_OK         = 2'd0;
    localparam t_status ST_INCOMPLETE = 2'd1;
    localparam t_status ST_MALFORMED  = 2'd2;

    typedef struct packed {
        logic [15:0] trans_id;
        logic [7:0]  unit_id;
        logic [6:0]  function_code;
        logic        exc_flag;
        logic [7:0]  exc_code;
        logic        reg_vld;
        logic [15:0] reg_value;
        logic [6:0]  reg_index;
        logic        cls_vld;
        logic [6:0]  cls_index;
        t_status     status;
    } t_entry;

endpackage

FILE: hdl/mtrd_front.sv
// Byte parser: tracks frame position, latches header fields, builds result entries.
module mtrd_front (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_take,
    input  logic [7:0]          i_rx_byte,
    input  logic                i_end_of_buffer,
    output logic                o_wr,
    output mtrd_pkg::t_entry    o_entry
);

    logic [16:0] r_pos,   n_pos;
    logic [15:0] r_trans, n_trans;
    logic [15:0] r_len,   n_len;
    logic [7:0]  r_unit,  n_unit;
    logic [7:0]  r_func,  n_func;
    logic [7:0]  r_code,  n_code;
    logic [7:0]  r_hi,    n_hi;
    logic [6:0]  r_sent,  n_sent;
    logic        r_closed, n_closed;

    logic        plain, is_rd, is_ws;
    logic [16:0] off;
    logic [15:0] pair;
    logic [7:0]  rc;
    logic        rd_zone, rd_latch, rd_emit, ws_latch, ws_emit, reg_emit;
    logic [16:0] total;
    logic [17:0] pos_next;
    logic        close;
    logic [8:0]  need;
    mtrd_pkg::t_status cls_status;

    assign plain = (r_func & mtrd_pkg::EXC_BIT) == 8'd0;
    assign is_rd = plain && (r_func[6:0] == mtrd_pkg::FC_READ_HOLDING ||
                             r_func[6:0] == mtrd_pkg::FC_READ_INPUT);
    assign is_ws = plain && (r_func[6:0] == mtrd_pkg::FC_WRITE_SINGLE);

    assign off     = r_pos - mtrd_pkg::POS_DATA;
    assign pair    = off[16:1];
    assign rc      = {1'b0, r_code[7:1]};
    assign rd_zone = (r_pos >= mtrd_pkg::POS_DATA) && is_rd;
    assign rd_latch = rd_zone && !off[0];
    assign rd_emit  = rd_zone && off[0] && (pair < {8'd0, rc});
    assign ws_latch = !rd_zone && is_ws && (r_pos == mtrd_pkg::POS_WS_HI);
    assign ws_emit  = !rd_zone && is_ws && (r_pos == mtrd_pkg::POS_WS_LO);
    assign reg_emit = rd_emit || ws_emit;

    always_comb begin
        n_trans = r_trans;
        n_len   = r_len;
        n_unit  = r_unit;
        n_func  = r_func;
        n_code  = r_code;
        n_hi    = r_hi;
        unique case (1'b1)
            (r_pos == mtrd_pkg::POS_TID_HI || r_pos == mtrd_pkg::POS_TID_LO): begin
                n_trans = {r_trans[7:0], i_rx_byte};
            end
            (r_pos == mtrd_pkg::POS_LEN_HI || r_pos == mtrd_pkg::POS_LEN_LO): begin
                n_len = {r_len[7:0], i_rx_byte};
            end
            (r_pos == mtrd_pkg::POS_UNIT): n_unit = i_rx_byte;
            (r_pos == mtrd_pkg::POS_FUNC): n_func = i_rx_byte;
            (r_pos == mtrd_pkg::POS_COUNT): n_code = i_rx_byte;
            default: begin
                if (rd_latch || ws_latch) begin
                    n_hi = i_rx_byte;
                end
            end
        endcase
    end

    always_comb begin
        if (rd_emit) begin
            n_sent = pair[6:0] + 7'd1;
        end else if (ws_emit) begin
            n_sent = 7'd1;
        end else begin
            n_sent = r_sent;
        end
    end

    assign total    = mtrd_pkg::HDR_LEN + {1'b0, n_len};
    assign pos_next = {1'b0, r_pos} + 18'd1;
    assign close    = (r_pos >= mtrd_pkg::POS_LEN_LO) && (pos_next >= {1'b0, total});

    always_comb begin
        if (n_func[7]) begin
            need = mtrd_pkg::NEED_EXC;
        end else if (n_func[6:0] == mtrd_pkg::FC_READ_HOLDING ||
                     n_func[6:0] == mtrd_pkg::FC_READ_INPUT) begin
            need = mtrd_pkg::NEED_EXC + {1'b0, n_code[7:1], 1'b0};
        end else if (n_func[6:0] == mtrd_pkg::FC_WRITE_SINGLE) begin
            need = mtrd_pkg::NEED_WS;
        end else begin
            need = mtrd_pkg::NEED_PLAIN;
        end
        if (close) begin
            cls_status = (total < {8'd0, need}) ? mtrd_pkg::ST_MALFORMED : mtrd_pkg::ST_OK;
        end else begin
            cls_status = mtrd_pkg::ST_INCOMPLETE;
        end
    end

    always_comb begin
        o_entry.trans_id       = n_trans;
        o_entry.unit_id        = n_unit;
        o_entry.function_code  = n_func[6:0];
        o_entry.exc_flag       = n_func[7];
        o_entry.exc_code       = n_func[7] ? n_code : 8'd0;
        o_entry.reg_vld        = reg_emit;
        o_entry.reg_value      = {r_hi, i_rx_byte};
        o_entry.reg_index      = rd_emit ? pair[6:0] : 7'd0;
        o_entry.cls_vld        = close || i_end_of_buffer;
        o_entry.cls_index      = n_sent;
        o_entry.status         = cls_status;
    end

    assign o_wr = i_take && !r_closed && (reg_emit || close || i_end_of_buffer);

    assign n_pos    = pos_next[16:0];
    assign n_closed = close;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pos    <= '0;
            r_trans  <= '0;
            r_len    <= '0;
            r_unit   <= '0;
            r_func   <= '0;
            r_code   <= '0;
            r_hi     <= '0;
            r_sent   <= '0;
            r_closed <= 1'b0;
        end else if (i_take) begin
            if (i_end_of_buffer) begin
                r_pos    <= '0;
                r_trans  <= '0;
                r_len    <= '0;
                r_unit   <= '0;
                r_func   <= '0;
                r_code   <= '0;
                r_hi     <= '0;
                r_sent   <= '0;
                r_closed <= 1'b0;
            end else if (!r_closed) begin
                r_pos    <= n_pos;
                r_trans  <= n_trans;
                r_len    <= n_len;
                r_unit   <= n_unit;
                r_func   <= n_func;
                r_code   <= n_code;
                r_hi     <= n_hi;
                r_sent   <= n_sent;
                r_closed <= n_closed;
            end
        end
    end

endmodule

FILE: hdl/mtrd_queue.sv
// Short entry queue between the byte parser and the result emitter.
module mtrd_queue #(
    parameter int DEPTH = mtrd_pkg::QUEUE_DEPTH
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_wr,
    input  mtrd_pkg::t_entry    i_entry,
    input  logic                i_rd,
    output mtrd_pkg::t_entry    o_head,
    output logic                o_full,
    output logic                o_empty
);

    localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CW = $clog2(DEPTH + 1);

    mtrd_pkg::t_entry r_mem [DEPTH];
    logic [PW-1:0] r_wptr, n_wptr;
    logic [PW-1:0] r_rptr, n_rptr;
    logic [CW-1:0] r_cnt;
    logic          wr_en, rd_en;

    assign o_full  = (r_cnt == CW'(DEPTH));
    assign o_empty = (r_cnt == '0);
    assign wr_en   = i_wr && !o_full;
    assign rd_en   = i_rd && !o_empty;
    assign o_head  = r_mem[r_rptr];

    assign n_wptr = (r_wptr == PW'(DEPTH - 1)) ? '0 : r_wptr + PW'(1);
    assign n_rptr = (r_rptr == PW'(DEPTH - 1)) ? '0 : r_rptr + PW'(1);

    always_ff @(posedge i_clk) begin
        if (wr_en) begin
            r_mem[r_wptr] <= i_entry;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wptr <= '0;
            r_rptr <= '0;
            r_cnt  <= '0;
        end else begin
            if (wr_en) begin
                r_wptr <= n_wptr;
            end
            if (rd_en) begin
                r_rptr <= n_rptr;
            end
            case ({wr_en, rd_en})
                2'b10:   r_cnt <= r_cnt + CW'(1);
                2'b01:   r_cnt <= r_cnt - CW'(1);
                default: r_cnt <= r_cnt;
            endcase
        end
    end

endmodule

FILE: hdl/mtrd_back.sv
// Result emitter: turns each queued entry into a register word, a closing word, or both.
module mtrd_back (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  mtrd_pkg::t_entry    i_head,
    input  logic                i_empty,
    input  logic                i_pop,
    output logic                o_deq,
    output logic                o_frame_end,
    output logic [15:0]         o_trans_id,
    output logic [7:0]          o_unit_id,
    output logic [6:0]          o_function_code,
    output logic                o_exc_flag,
    output logic [7:0]          o_exc_code,
    output logic [15:0]         o_register_value,
    output logic [6:0]          o_register_index,
    output logic [1:0]          o_status
);

    logic r_second;
    logic take, both, is_cls;

    assign take   = i_pop && !i_empty;
    assign both   = i_head.reg_vld && i_head.cls_vld;
    assign is_cls = r_second || !i_head.reg_vld;
    assign o_deq  = take && (r_second || !both);

    assign o_frame_end      = is_cls;
    assign o_trans_id       = i_head.trans_id;
    assign o_unit_id        = i_head.unit_id;
    assign o_function_code  = i_head.function_code;
    assign o_exc_flag       = i_head.exc_flag;
    assign o_exc_code       = i_head.exc_code;
    assign o_register_value = is_cls ? 16'd0 : i_head.reg_value;
    assign o_register_index = is_cls ? i_head.cls_index : i_head.reg_index;
    assign o_status         = is_cls ? i_head.status : mtrd_pkg::ST_OK;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_second <= 1'b0;
        end else if (o_deq) begin
            r_second <= 1'b0;
        end else if (take) begin
            r_second <= 1'b1;
        end
    end

endmodule

FILE: hdl/modbus_tcp_response_deframer.sv
// Modbus TCP response deframer: top level joining parser, queue and emitter.
// Result words are registered in the queue when the byte that causes them is taken.
// Throughput: one byte per cycle while the queue is not full; a byte that gives
// a register word and the closing word yields both in turn on the single-word port.
// Reset: synchronous active low; clears frame tracking, queue pointers, emitter.
module modbus_tcp_response_deframer #(
    parameter int QUEUE_DEPTH = mtrd_pkg::QUEUE_DEPTH
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        push,
    output logic        full,
    input  logic [7:0]  i_rx_byte,
    input  logic        i_end_of_buffer,
    output logic        empty,
    input  logic        pop,
    output logic        o_frame_end,
    output logic [15:0] o_trans_id,
    output logic [7:0]  o_unit_id,
    output logic [6:0]  o_function_code,
    output logic        o_exc_flag,
    output logic [7:0]  o_exc_code,
    output logic [15:0] o_register_value,
    output logic [6:0]  o_register_index,
    output logic [1:0]  o_status
);

    logic             take, wr, deq;
    mtrd_pkg::t_entry wr_entry, head;

    assign take = push && !full;

    mtrd_front u_front (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_take          (take),
        .i_rx_byte       (i_rx_byte),
        .i_end_of_buffer (i_end_of_buffer),
        .o_wr            (wr),
        .o_entry         (wr_entry)
    );

    mtrd_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_wr    (wr),
        .i_entry (wr_entry),
        .i_rd    (deq),
        .o_head  (head),
        .o_full  (full),
        .o_empty (empty)
    );

    mtrd_back u_back (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_head           (head),
        .i_empty          (empty),
        .i_pop            (pop),
        .o_deq            (deq),
        .o_frame_end      (o_frame_end),
        .o_trans_id       (o_trans_id),
        .o_unit_id        (o_unit_id),
        .o_function_code  (o_function_code),
        .o_exc_flag       (o_exc_flag),
        .o_exc_code       (o_exc_code),
        .o_register_value (o_register_value),
        .o_register_index (o_register_index),
        .o_status         (o_status)
    );

endmodule
